// File: hw/rtl/buzzer_note_tone_timing_core_macros.svh
// Assertion macros for the buzzer note tone and timing core.
// Both expect clk and rst_n in scope; checks are off while reset is asserted.
`ifndef BUZZER_NOTE_TONE_TIMING_CORE_MACROS_SVH
`define BUZZER_NOTE_TONE_TIMING_CORE_MACROS_SVH
`ifndef SYNTH
`define BNTT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bntt: same-cycle check failed");
`define BNTT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bntt: next-cycle check failed");
`else
`define BNTT_ASSERT_IMP(label, ante, cons)
`define BNTT_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/bntt_pkg.sv
package bntt_pkg;

    // field widths
    localparam int FREQ_W    = 16;
    localparam int DIVR_W    = 16;
    localparam int ELAPSED_W = 32;
    localparam int TEMPO_W   = 16;
    localparam int VOL_W     = 7;
    localparam int RELOAD_W  = 20;
    localparam int CMP_W     = 19;
    localparam int SOUND_W   = 19;
    localparam int GAP_W     = 16;

    // internal widths
    localparam int WHOLE_W   = 18;  // 240000 ms whole note at tempo 1
    localparam int DUR_W     = 19;  // dotted whole note, 360000 ms
    localparam int PROD_W    = 27;  // reload * volume, up to 1e8

    // divide by 200: drop three bits (200 = 8 * 25), then multiply by ceil(2^29/25)
    localparam int DUTY_PRE_SH = 3;
    localparam int DUTY_RCP_W  = 25;
    localparam int DUTY_SH     = 29;
    localparam int DUTY_MUL_W  = PROD_W - DUTY_PRE_SH + DUTY_RCP_W;

    // divide by 10: multiply by ceil(2^23/10), exact for any 19-bit duration
    localparam int TENTH_RCP_W = 20;
    localparam int TENTH_SH    = 23;
    localparam int TENTH_MUL_W = DUR_W + TENTH_RCP_W;

    // constants
    localparam logic [RELOAD_W-1:0] TIMER_CLK     = RELOAD_W'(1000000);
    localparam logic [WHOLE_W-1:0]  WHOLE_NUM     = WHOLE_W'(240000);
    localparam logic [DUTY_RCP_W-1:0]  DUTY_RCP   = DUTY_RCP_W'(21474837);
    localparam logic [TENTH_RCP_W-1:0] TENTH_RCP  = TENTH_RCP_W'(838861);
    localparam logic [VOL_W-1:0]    VOL_MAX       = VOL_W'(100);
    localparam logic [VOL_W-1:0]    VOL_FADE_1    = VOL_W'(10);
    localparam logic [VOL_W-1:0]    VOL_FADE_2    = VOL_W'(20);
    localparam logic [VOL_W-1:0]    VOL_FADE_3    = VOL_W'(35);
    localparam logic [ELAPSED_W-1:0] FADE_STEP_1  = ELAPSED_W'(4000);
    localparam logic [ELAPSED_W-1:0] FADE_STEP_2  = ELAPSED_W'(8000);
    localparam logic [ELAPSED_W-1:0] FADE_STEP_3  = ELAPSED_W'(12000);

    // register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPO_BPM    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_ENABLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_VOLUME = 2'd2;
    localparam logic [TEMPO_W-1:0]   TEMPO_RESET      = TEMPO_W'(120);

    // path depths in register stages (tone path is padded to the duration path)
    localparam int TONE_LAT  = RELOAD_W + 2;
    localparam int DUR_LAT   = WHOLE_W + WHOLE_W + 3;
    localparam int ALIGN_LAT = DUR_LAT - TONE_LAT;

    typedef struct packed {
        logic                wr;
        logic [RELOAD_W-1:0] reload;
        logic [CMP_W-1:0]    cmp;
        logic [VOL_W-1:0]    vol;
    } tone_res_t;

    typedef struct packed {
        logic [SOUND_W-1:0] sound;
        logic [GAP_W-1:0]   gap;
    } dur_res_t;

    function automatic logic [VOL_W-1:0] pick_volume(
        input logic [ELAPSED_W-1:0] elapsed,
        input logic                 fade,
        input logic [VOL_W-1:0]     fixed_vol
    );
        logic [VOL_W-1:0] v;
        if (fade) begin
            if (elapsed < FADE_STEP_1)
                v = VOL_FADE_1;
            else if (elapsed < FADE_STEP_2)
                v = VOL_FADE_2;
            else if (elapsed < FADE_STEP_3)
                v = VOL_FADE_3;
            else
                v = VOL_MAX;
        end
        else begin
            v = (fixed_vol > VOL_MAX) ? VOL_MAX : fixed_vol;
        end
        return v;
    endfunction

endpackage

// File: hw/rtl/bntt_div_pipe.sv
// Restoring divider, one quotient bit per register stage, MSB first.
// A zero divisor gives an all-ones quotient; callers mask that case.
module bntt_div_pipe #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 16,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_vld,
    output logic [NUM_W-1:0] quo,
    output logic [TAG_W-1:0] out_tag
);

    logic             vld_reg [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] quo_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [TAG_W-1:0] tag_reg [NUM_W];

    logic [DEN_W-1:0] rem_next [NUM_W];
    logic [NUM_W-1:0] quo_next [NUM_W];

    for (genvar j = 0; j < NUM_W; j++) begin : g_stage
        logic             vld_prev;
        logic [DEN_W-1:0] rem_prev;
        logic [NUM_W-1:0] quo_prev;
        logic [NUM_W-1:0] num_prev;
        logic [DEN_W-1:0] den_prev;
        logic [TAG_W-1:0] tag_prev;
        logic [DEN_W:0]   trial;
        logic             take;

        if (j == 0) begin : g_first
            assign vld_prev = in_vld;
            assign rem_prev = '0;
            assign quo_prev = '0;
            assign num_prev = num;
            assign den_prev = den;
            assign tag_prev = in_tag;
        end
        else begin : g_chain
            assign vld_prev = vld_reg[j-1];
            assign rem_prev = rem_reg[j-1];
            assign quo_prev = quo_reg[j-1];
            assign num_prev = num_reg[j-1];
            assign den_prev = den_reg[j-1];
            assign tag_prev = tag_reg[j-1];
        end

        assign trial       = {rem_prev, num_prev[NUM_W-1-j]};
        assign take        = (trial >= {1'b0, den_prev});
        assign rem_next[j] = take ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
        assign quo_next[j] = {quo_prev[NUM_W-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else
                vld_reg[j] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= rem_next[j];
            quo_reg[j] <= quo_next[j];
            num_reg[j] <= num_prev;
            den_reg[j] <= den_prev;
            tag_reg[j] <= tag_prev;
        end
    end

    assign out_vld = vld_reg[NUM_W-1];
    assign quo     = quo_reg[NUM_W-1];
    assign out_tag = tag_reg[NUM_W-1];

endmodule

// File: hw/rtl/bntt_tone_path.sv
// Timer reload = 1e6/freq, compare = reload*vol/200.
module bntt_tone_path
    import bntt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [FREQ_W-1:0] freq,
    input  logic [VOL_W-1:0]  vol,
    output logic              out_vld,
    output tone_res_t         res
);

    typedef struct packed {
        logic             active;
        logic [VOL_W-1:0] vol;
    } rld_tag_t;

    typedef struct packed {
        logic                wr;
        logic [RELOAD_W-1:0] reload;
        logic [VOL_W-1:0]    vol;
    } cmp_tag_t;

    rld_tag_t            rld_tag_in;
    rld_tag_t            rld_tag_out;
    logic                rld_vld;
    logic [RELOAD_W-1:0] rld_quo;

    logic                mul_vld_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    cmp_tag_t            mul_tag_reg;
    cmp_tag_t            mul_tag_next;

    logic [DUTY_MUL_W-1:0] duty_prod;
    logic                duty_vld_reg;
    logic [CMP_W-1:0]    cmp_reg;
    cmp_tag_t            duty_tag_reg;

    assign rld_tag_in.active = (freq != '0) && (vol != '0);
    assign rld_tag_in.vol    = vol;

    bntt_div_pipe #(
        .NUM_W (RELOAD_W),
        .DEN_W (FREQ_W),
        .TAG_W ($bits(rld_tag_t))
    ) u_reload_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (in_vld),
        .num     (TIMER_CLK),
        .den     (freq),
        .in_tag  (rld_tag_in),
        .out_vld (rld_vld),
        .quo     (rld_quo),
        .out_tag (rld_tag_out)
    );

    // rests and silent notes carry a zero reload and product from here on
    always_comb
    begin
        prod_next           = rld_tag_out.active
                              ? PROD_W'(rld_quo) * PROD_W'(rld_tag_out.vol) : '0;
        mul_tag_next.wr     = rld_tag_out.active;
        mul_tag_next.reload = rld_tag_out.active ? rld_quo : '0;
        mul_tag_next.vol    = rld_tag_out.vol;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_vld_reg <= 1'b0;
        else
            mul_vld_reg <= rld_vld;
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        mul_tag_reg <= mul_tag_next;
    end

    // floor(p/200) = floor(floor(p/8)/25), the /25 by reciprocal multiply
    assign duty_prod = DUTY_MUL_W'(prod_reg[PROD_W-1:DUTY_PRE_SH]) * DUTY_MUL_W'(DUTY_RCP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            duty_vld_reg <= 1'b0;
        else
            duty_vld_reg <= mul_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        cmp_reg      <= duty_prod[DUTY_SH +: CMP_W];
        duty_tag_reg <= mul_tag_reg;
    end

    assign out_vld    = duty_vld_reg;
    assign res.wr     = duty_tag_reg.wr;
    assign res.reload = duty_tag_reg.reload;
    assign res.cmp    = cmp_reg;
    assign res.vol    = duty_tag_reg.vol;

endmodule

// File: hw/rtl/bntt_dur_path.sv
// Whole note, note duration (dotted x1.5), divide by ten, then 90/10 split.
module bntt_dur_path
    import bntt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  logic [TEMPO_W-1:0] tempo,
    input  logic [DIVR_W-1:0]  mag,
    input  logic               dotted,
    input  logic               zero_len,
    output logic               out_vld,
    output dur_res_t           res
);

    typedef struct packed {
        logic [DIVR_W-1:0] mag;
        logic              dotted;
        logic              zero_len;
    } whole_tag_t;

    typedef struct packed {
        logic dotted;
        logic zero_len;
    } note_tag_t;

    logic [TEMPO_W-1:0] tempo_eff;
    whole_tag_t         whole_tag_in;
    whole_tag_t         whole_tag_out;
    logic               whole_vld;
    logic [WHOLE_W-1:0] whole_quo;

    note_tag_t          note_tag_in;
    note_tag_t          note_tag_out;
    logic               note_vld;
    logic [WHOLE_W-1:0] base;

    logic               dot_vld_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic [DUR_W-1:0]   dur_next;

    logic [TENTH_MUL_W-1:0] ten_prod;
    logic               ten_vld_reg;
    logic [GAP_W-1:0]   ten_quo_reg;
    logic [DUR_W-1:0]   ten_dur_reg;
    logic [DUR_W-1:0]   ten_quo_ext;
    logic [DUR_W-1:0]   ten_back;
    logic               ten_rem_nz;

    logic               fin_vld_reg;
    dur_res_t           fin_reg;
    dur_res_t           fin_next;

    // tempo 0 behaves as tempo 1
    assign tempo_eff             = (tempo == '0) ? TEMPO_W'(1) : tempo;
    assign whole_tag_in.mag      = mag;
    assign whole_tag_in.dotted   = dotted;
    assign whole_tag_in.zero_len = zero_len;

    bntt_div_pipe #(
        .NUM_W (WHOLE_W),
        .DEN_W (TEMPO_W),
        .TAG_W ($bits(whole_tag_t))
    ) u_whole_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (in_vld),
        .num     (WHOLE_NUM),
        .den     (tempo_eff),
        .in_tag  (whole_tag_in),
        .out_vld (whole_vld),
        .quo     (whole_quo),
        .out_tag (whole_tag_out)
    );

    assign note_tag_in.dotted   = whole_tag_out.dotted;
    assign note_tag_in.zero_len = whole_tag_out.zero_len;

    bntt_div_pipe #(
        .NUM_W (WHOLE_W),
        .DEN_W (DIVR_W),
        .TAG_W ($bits(note_tag_t))
    ) u_note_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (whole_vld),
        .num     (whole_quo),
        .den     (whole_tag_out.mag),
        .in_tag  (note_tag_in),
        .out_vld (note_vld),
        .quo     (base),
        .out_tag (note_tag_out)
    );

    // dotted: base + base/2
    always_comb
    begin
        if (note_tag_out.zero_len)
            dur_next = '0;
        else if (note_tag_out.dotted)
            dur_next = DUR_W'(base) + DUR_W'(base >> 1);
        else
            dur_next = DUR_W'(base);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dot_vld_reg <= 1'b0;
        else
            dot_vld_reg <= note_vld;
    end

    always_ff @(posedge clk)
    begin
        dur_reg <= dur_next;
    end

    // d/10 by reciprocal multiply
    assign ten_prod = TENTH_MUL_W'(dur_reg) * TENTH_MUL_W'(TENTH_RCP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ten_vld_reg <= 1'b0;
        else
            ten_vld_reg <= dot_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        ten_quo_reg <= ten_prod[TENTH_SH +: GAP_W];
        ten_dur_reg <= dur_reg;
    end

    // floor(9d/10) = d - ceil(d/10)
    assign ten_quo_ext    = DUR_W'(ten_quo_reg);
    assign ten_back       = (ten_quo_ext << 3) + (ten_quo_ext << 1);
    assign ten_rem_nz     = (ten_back != ten_dur_reg);
    assign fin_next.sound = ten_dur_reg - ten_quo_ext - DUR_W'(ten_rem_nz);
    assign fin_next.gap   = ten_quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_vld_reg <= 1'b0;
        else
            fin_vld_reg <= ten_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        fin_reg <= fin_next;
    end

    assign out_vld = fin_vld_reg;
    assign res     = fin_reg;

endmodule

// File: hw/rtl/buzzer_note_tone_timing_core.sv
// Buzzer note tone and timing core. Give it one melody note per clock (start
// high; busy is never raised, so every start is a transfer) and, once the note
// has passed the register stages below, done rises for one cycle with the PWM
// timer reload and compare counts, the volume used and the sound and gap
// lengths of that note. Notes may follow each other in every cycle, giving
// one result per cycle, in order. The 41 register stages are the depth of the
// duration chain: input register, whole-note and note-length dividers (18
// quotient bits each, one per stage), the dotted-note stage, a reciprocal
// multiply for the divide by ten, the split stage and the output register.
// The receiver cannot stall: results are shown for one cycle only and must be
// taken then. Configuration writes land on the next edge and should be made
// only with no note in flight.
`include "buzzer_note_tone_timing_core_macros.svh"

module buzzer_note_tone_timing_core
    import bntt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // note in
    input  logic                  start,
    output logic                  busy,
    input  logic [FREQ_W-1:0]     tone_freq,
    input  logic signed [DIVR_W-1:0] length_divider,
    input  logic [ELAPSED_W-1:0]  alarm_age_ms,

    // result out
    output logic                  done,
    output logic                  reload_write,
    output logic [RELOAD_W-1:0]   reload_value,
    output logic [CMP_W-1:0]      compare_value,
    output logic [VOL_W-1:0]      volume_used,
    output logic [SOUND_W-1:0]    sound_ms,
    output logic [GAP_W-1:0]      gap_ms,

    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [TEMPO_W-1:0] tempo_reg;
    logic               fade_reg;
    logic [VOL_W-1:0]   fixed_vol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tempo_reg     <= TEMPO_RESET;
            fade_reg      <= 1'b0;
            fixed_vol_reg <= VOL_MAX;
        end
        else if (cfg_we) begin
            case (cfg_idx)
                REG_TEMPO_BPM:    tempo_reg     <= cfg_wdata[TEMPO_W-1:0];
                REG_FADE_ENABLE:  fade_reg      <= cfg_wdata[0];
                REG_FIXED_VOLUME: fixed_vol_reg <= cfg_wdata[VOL_W-1:0];
                default:          ; // unmapped index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input stage: volume pick and divider decode.
    // Every cycle can take a transfer, the pipeline never stalls.
    // ---------------------------------------------------------------
    logic              accept;
    logic              in_vld_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [VOL_W-1:0]  vol_reg;
    logic [VOL_W-1:0]  vol_next;
    logic [DIVR_W-1:0] mag_reg;
    logic [DIVR_W-1:0] mag_next;
    logic              dotted_reg;
    logic              zero_len_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign vol_next = pick_volume(alarm_age_ms, fade_reg, fixed_vol_reg);
    // magnitude of a negative divider; -32768 comes out as 32768
    assign mag_next = length_divider[DIVR_W-1] ? (DIVR_W'(0) - $unsigned(length_divider))
                                               : $unsigned(length_divider);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        freq_reg     <= tone_freq;
        vol_reg      <= vol_next;
        mag_reg      <= mag_next;
        dotted_reg   <= length_divider[DIVR_W-1];
        zero_len_reg <= (length_divider == '0);
    end

    // ---------------------------------------------------------------
    // Tone path (reload/compare) and duration path run side by side
    // ---------------------------------------------------------------
    logic      tone_vld;
    tone_res_t tone_res;
    logic      dur_vld;
    dur_res_t  dur_res;

    bntt_tone_path u_tone (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (in_vld_reg),
        .freq    (freq_reg),
        .vol     (vol_reg),
        .out_vld (tone_vld),
        .res     (tone_res)
    );

    bntt_dur_path u_dur (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (in_vld_reg),
        .tempo    (tempo_reg),
        .mag      (mag_reg),
        .dotted   (dotted_reg),
        .zero_len (zero_len_reg),
        .out_vld  (dur_vld),
        .res      (dur_res)
    );

    // Tone path is shorter; pad it so both halves of a note meet
    logic      dly_vld_reg [ALIGN_LAT];
    tone_res_t dly_reg     [ALIGN_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < ALIGN_LAT; i++)
                dly_vld_reg[i] <= 1'b0;
        end
        else begin
            dly_vld_reg[0] <= tone_vld;
            for (int i = 1; i < ALIGN_LAT; i++)
                dly_vld_reg[i] <= dly_vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        dly_reg[0] <= tone_res;
        for (int i = 1; i < ALIGN_LAT; i++)
            dly_reg[i] <= dly_reg[i-1];
    end

    // ---------------------------------------------------------------
    // Output register: one-cycle result strobe
    // ---------------------------------------------------------------
    logic      done_reg;
    tone_res_t out_tone_reg;
    dur_res_t  out_dur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dur_vld;
    end

    always_ff @(posedge clk)
    begin
        out_tone_reg <= dly_reg[ALIGN_LAT-1];
        out_dur_reg  <= dur_res;
    end

    assign done          = done_reg;
    assign reload_write  = out_tone_reg.wr;
    assign reload_value  = out_tone_reg.reload;
    assign compare_value = out_tone_reg.cmp;
    assign volume_used   = out_tone_reg.vol;
    assign sound_ms      = out_dur_reg.sound;
    assign gap_ms        = out_dur_reg.gap;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // both halves of a note leave their paths on the same cycle
    `BNTT_ASSERT_IMP(a_path_align, 1'b1, dur_vld == dly_vld_reg[ALIGN_LAT-1])
    // a finished duration is shown on the next cycle
    `BNTT_ASSERT_NXT(a_done_follows, dur_vld, done)
    // no reload write means a silent timer
    `BNTT_ASSERT_IMP(a_silent, done && !reload_write, reload_value == '0 && compare_value == '0)
    // duty never exceeds one half
    `BNTT_ASSERT_IMP(a_duty_half, done, {compare_value, 1'b0} <= reload_value)
    // sound part is at least nine gaps long
    `BNTT_ASSERT_IMP(a_split, done, (SOUND_W + 4)'(sound_ms) >= (SOUND_W + 4)'(gap_ms) * 9)

endmodule

// File: sim/buzzer_note_tone_timing_core_tb.sv
module buzzer_note_tone_timing_core_tb;

    import bntt_pkg::*;

    // Unused slot of the register map: writes there must leave every setting alone.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Cycles with no transfer on either side before the run is called hung.
    // The slowest honest wait is one pipeline drain plus the longest drawn gap.
    localparam int unsigned STALL_LIMIT = 2000;
    // Settling time after the last result: well over the pipeline depth.
    localparam int unsigned TAIL_CYCLES = 80;
    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned NOTES_PER_PHASE = 150;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct {
        logic [FREQ_W-1:0]        freq;
        logic signed [DIVR_W-1:0] divider;
        logic [ELAPSED_W-1:0]     elapsed;
    } note_item_t;

    typedef struct packed {
        logic                wr;
        logic [RELOAD_W-1:0] reload;
        logic [CMP_W-1:0]    cmp;
        logic [VOL_W-1:0]    vol;
        logic [SOUND_W-1:0]  sound;
        logic [GAP_W-1:0]    gap;
    } note_result_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                     start = 1'b0;
    logic                     busy;
    logic [FREQ_W-1:0]        tone_freq = '0;
    logic signed [DIVR_W-1:0] length_divider = '0;
    logic [ELAPSED_W-1:0]     alarm_age_ms = '0;

    logic                done;
    logic                reload_write;
    logic [RELOAD_W-1:0] reload_value;
    logic [CMP_W-1:0]    compare_value;
    logic [VOL_W-1:0]    volume_used;
    logic [SOUND_W-1:0]  sound_ms;
    logic [GAP_W-1:0]    gap_ms;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow copy of the register file, as left by reset.
    logic [TEMPO_W-1:0] tempo_cfg = 16'd120;
    logic               fade_cfg = 1'b0;
    logic [VOL_W-1:0]   volume_cfg = 7'd100;

    note_item_t   note_queue[$];    // notes still to be offered
    note_result_t due_notes[$];     // predicted results, oldest first
    note_item_t   next_note;
    note_result_t seen_note;
    note_result_t want_note;

    int unsigned notes_issued = 0;
    int unsigned notes_taken = 0;
    int unsigned fail_count = 0;
    int unsigned hold_off = 0;
    logic        burst = 1'b0;

    buzzer_note_tone_timing_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .tone_freq      (tone_freq),
        .length_divider (length_divider),
        .alarm_age_ms   (alarm_age_ms),
        .done           (done),
        .reload_write   (reload_write),
        .reload_value   (reload_value),
        .compare_value  (compare_value),
        .volume_used    (volume_used),
        .sound_ms       (sound_ms),
        .gap_ms         (gap_ms),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_wdata      (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Timer settings and note timing for one note under the shadow registers.
    // All sums are done at 32 bits unsigned, then cut to the port widths.
    function automatic note_result_t predict_note(
        input logic [FREQ_W-1:0]        freq,
        input logic signed [DIVR_W-1:0] divider,
        input logic [ELAPSED_W-1:0]     elapsed
    );
        note_result_t r;
        logic [31:0]  vol;
        logic [31:0]  reload;
        logic [31:0]  tempo;
        logic [31:0]  whole;
        logic [31:0]  dur;
        logic [15:0]  div_bits;
        r = '0;
        if (fade_cfg)
        begin
            if (elapsed < 32'd4000)
                vol = 32'd10;
            else if (elapsed < 32'd8000)
                vol = 32'd20;
            else if (elapsed < 32'd12000)
                vol = 32'd35;
            else
                vol = 32'd100;
        end
        else
        begin
            vol = (volume_cfg > 7'd100) ? 32'd100 : 32'(volume_cfg);
        end
        // a rest or a silent volume leaves the timer alone
        if (freq != '0 && vol != 32'd0)
        begin
            reload = 32'd1000000 / 32'(freq);
            r.wr = 1'b1;
            r.reload = RELOAD_W'(reload);
            r.cmp = CMP_W'((reload * vol) / 32'd200);
        end
        r.vol = VOL_W'(vol);
        tempo = (tempo_cfg == '0) ? 32'd1 : 32'(tempo_cfg);
        whole = 32'd240000 / tempo;
        div_bits = divider;
        if (div_bits == 16'd0)
            dur = 32'd0;
        else if (div_bits[15])
            dur = ((whole / (32'h10000 - 32'(div_bits))) * 32'd3) / 32'd2;    // dotted
        else
            dur = whole / 32'(div_bits);
        r.sound = SOUND_W'((dur * 32'd9) / 32'd10);
        r.gap = GAP_W'(dur / 32'd10);
        return r;
    endfunction

    task automatic queue_note(
        input logic [FREQ_W-1:0]        freq,
        input logic signed [DIVR_W-1:0] divider,
        input logic [ELAPSED_W-1:0]     elapsed
    );
        note_item_t n;
        n.freq = freq;
        n.divider = divider;
        n.elapsed = elapsed;
        note_queue.push_back(n);
        notes_issued++;
    endtask

    // One register write, one cycle wide; the shadow copy follows at once since
    // nothing is in flight when this is called.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TEMPO_BPM:    tempo_cfg = data[TEMPO_W-1:0];
            REG_FADE_ENABLE:  fade_cfg = data[0];
            REG_FIXED_VOLUME: volume_cfg = data[VOL_W-1:0];
            default:          ;
        endcase
    endtask

    // Every offered note taken and every result back. The counters rather than
    // start are used, so a note being loaded at this very edge is not missed.
    task automatic wait_drained;
        while (notes_taken != notes_issued || due_notes.size() != 0)
            @(posedge clk);
    endtask

    // Note driver: a transfer happens at an edge with start high and busy low.
    // The fields seen at that edge are still the old ones here, so the
    // prediction uses exactly what the block took. With each note loaded, a gap
    // before the next is drawn, except during bursts where notes go back to back.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            hold_off <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                due_notes.push_back(predict_note(tone_freq, length_divider, alarm_age_ms));
                notes_taken++;
            end
            if (!start || !busy)
            begin
                if (hold_off != 0)
                begin
                    start <= 1'b0;
                    hold_off <= hold_off - 1;
                end
                else if (note_queue.size() != 0)
                begin
                    next_note = note_queue.pop_front();
                    tone_freq <= next_note.freq;
                    length_divider <= next_note.divider;
                    alarm_age_ms <= next_note.elapsed;
                    start <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        burst = !burst;
                    hold_off <= burst ? 0 : $urandom_range(0, 12);
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: done marks a one-cycle result, taken at the edge ending it.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen_note.wr = reload_write;
            seen_note.reload = reload_value;
            seen_note.cmp = compare_value;
            seen_note.vol = volume_used;
            seen_note.sound = sound_ms;
            seen_note.gap = gap_ms;
            if (due_notes.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result with no note outstanding", $realtime);
            end
            else
            begin
                want_note = due_notes.pop_front();
                if (seen_note !== want_note)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"%0t: note mismatch exp wr %0d reload %0d cmp %0d vol %0d",
                                  " sound %0d gap %0d / got wr %0d reload %0d cmp %0d vol %0d",
                                  " sound %0d gap %0d"}, $realtime,
                                 want_note.wr, want_note.reload, want_note.cmp, want_note.vol,
                                 want_note.sound, want_note.gap,
                                 seen_note.wr, seen_note.reload, seen_note.cmp, seen_note.vol,
                                 seen_note.sound, seen_note.gap);
                end
            end
        end
    end

    // Hang guard: ends the run once nothing has moved for too long.
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                quiet = 0;
            else
                quiet++;
        end
        $display("** buzzer_note_tone_timing_core: FAILED **");
        $finish;
    end

    initial
    begin
        int unsigned              ph;
        int unsigned              k;
        logic [FREQ_W-1:0]        freq;
        logic signed [DIVR_W-1:0] divider;
        logic [ELAPSED_W-1:0]     elapsed;
        logic [CFG_DATA_W-1:0]    word;
        logic [VOL_W-1:0]         vol;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: 120 bpm (whole note 2000 ms), fixed volume 100.
        queue_note(16'd0, 16'sd4, 32'd0);               // rest
        queue_note(16'd1, 16'sd1, 32'd0);               // longest period, full duty half
        queue_note(16'hFFFF, -16'sd1, 32'hFFFF_FFFF);   // shortest period, dotted whole
        queue_note(16'd15, 16'sd32767, 32'd0);          // largest divider
        queue_note(16'd440, -16'sd32768, 32'd100);      // most negative divider
        queue_note(16'd1000, 16'sd0, 32'd0);            // zero divider, no length
        queue_note(16'd262, 16'sd8, 32'd0);
        queue_note(16'd523, -16'sd4, 32'd0);
        wait_drained();

        // Fade-in: each step boundary from both sides.
        set_reg(REG_FADE_ENABLE, 16'h0001);
        queue_note(16'd880, 16'sd4, 32'd0);
        queue_note(16'd880, 16'sd4, 32'd3999);
        queue_note(16'd880, 16'sd4, 32'd4000);
        queue_note(16'd880, 16'sd4, 32'd7999);
        queue_note(16'd880, 16'sd4, 32'd8000);
        queue_note(16'd880, 16'sd4, 32'd11999);
        queue_note(16'd880, 16'sd4, 32'd12000);
        queue_note(16'd880, 16'sd4, 32'hFFFF_FFFF);
        queue_note(16'd0, -16'sd2, 32'd5000);           // rest during fade
        wait_drained();

        // Zero tempo reads as 1 bpm, volume 0 silences, fade off with junk
        // in the upper data bits, and a write to the spare slot is ignored.
        set_reg(REG_TEMPO_BPM, 16'd0);
        set_reg(REG_FADE_ENABLE, 16'hFFFE);
        set_reg(REG_FIXED_VOLUME, 16'h0000);
        set_reg(REG_SPARE, 16'hFFFF);
        queue_note(16'd440, 16'sd1, 32'd0);
        queue_note(16'd1, -16'sd1, 32'd0);              // longest note of all
        queue_note(16'hFFFF, -16'sd32768, 32'd0);
        wait_drained();

        // Volume above one hundred saturates; fastest tempo.
        set_reg(REG_FIXED_VOLUME, 16'hFFFF);
        set_reg(REG_TEMPO_BPM, 16'hFFFF);
        queue_note(16'd1, 16'sd1, 32'd0);
        queue_note(16'd100, -16'sd2, 32'd0);
        queue_note(16'd2000, 16'sd2, 32'd0);
        wait_drained();

        // Random part: a fresh register setting per phase, mostly plausible
        // melody notes with a share of raw bit patterns.
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 5))
                0:       word = 16'd0;
                1:       word = 16'd1;
                2:       word = 16'hFFFF;
                3, 4:    word = CFG_DATA_W'($urandom_range(40, 240));
                default: word = CFG_DATA_W'($urandom);
            endcase
            set_reg(REG_TEMPO_BPM, word);
            set_reg(REG_FADE_ENABLE, {15'($urandom), 1'($urandom_range(0, 1))});
            case ($urandom_range(0, 4))
                0:       vol = 7'd0;
                1:       vol = 7'd100;
                2:       vol = 7'd127;
                default: vol = VOL_W'($urandom_range(0, 127));
            endcase
            set_reg(REG_FIXED_VOLUME, {9'($urandom), vol});
            if ($urandom_range(0, 3) == 0)
                set_reg(REG_SPARE, CFG_DATA_W'($urandom));

            for (k = 0; k < NOTES_PER_PHASE; k++)
            begin
                case ($urandom_range(0, 9))
                    0:          freq = '0;
                    1:          freq = FREQ_W'($urandom_range(1, 30));
                    2, 3, 4:    freq = FREQ_W'($urandom_range(100, 5000));
                    default:    freq = FREQ_W'($urandom);
                endcase
                case ($urandom_range(0, 7))
                    0:          divider = '0;
                    1, 2, 3:
                    begin
                        divider = DIVR_W'(1 << $urandom_range(0, 5));
                        if ($urandom_range(0, 2) == 0)
                            divider = -divider;
                    end
                    default:    divider = DIVR_W'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0:          elapsed = ELAPSED_W'($urandom);
                    1, 2:       elapsed = ELAPSED_W'($urandom_range(0, 20000));
                    default:    elapsed = ELAPSED_W'(4000 * $urandom_range(1, 3)
                                                     + $urandom_range(0, 4) - 2);
                endcase
                queue_note(freq, divider, elapsed);
            end
            wait_drained();
        end

        // Let any stray result show itself before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && due_notes.size() == 0)
            $display("** buzzer_note_tone_timing_core: PASSED **");
        else
            $display("** buzzer_note_tone_timing_core: FAILED **");
        $finish;
    end

endmodule
